>>> sv/nec_ir_frame_decoder_assert.svh
// Assertion macros shared by the NEC infrared decoder modules.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nir_pkg.sv
// Types and constants shared by the NEC infrared frame decoder.
package nir_pkg;

    localparam int TICK_W      = 16;
    localparam int TOL_W       = 15;
    localparam int FRAME_BITS  = 32;
    localparam int BITCNT_W    = 5;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FRAME  = 2'd1,
        EV_REPEAT = 2'd2
    } event_t;

    localparam logic [2:0] REG_LEADER = 3'd0;
    localparam logic [2:0] REG_REPEAT = 3'd1;
    localparam logic [2:0] REG_ZERO   = 3'd2;
    localparam logic [2:0] REG_ONE    = 3'd3;
    localparam logic [2:0] REG_TOL    = 3'd4;

    localparam logic [TICK_W-1:0] LEADER_RST = 16'd12442;
    localparam logic [TICK_W-1:0] REPEAT_RST = 16'd10368;
    localparam logic [TICK_W-1:0] ZERO_RST   = 16'd1032;
    localparam logic [TICK_W-1:0] ONE_RST    = 16'd2074;
    localparam logic [TOL_W-1:0]  TOL_RST    = 15'd500;

    // Timing windows, all in timer ticks.
    typedef struct packed {
        logic [TICK_W-1:0] leader;
        logic [TICK_W-1:0] rpt;
        logic [TICK_W-1:0] zero;
        logic [TICK_W-1:0] one;
        logic [TOL_W-1:0]  tol;
    } cfg_t;

    // Which nominal windows one interval falls into.
    typedef struct packed {
        logic leader;
        logic rpt;
        logic zero;
        logic one;
    } match_t;

endpackage

>>> sv/nir_front.sv
// Front end: takes interval words and classifies them against the timing windows.
module nir_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [nir_pkg::TICK_W-1:0]  s_interval,
    input  nir_pkg::cfg_t               cfg,
    input  logic                        q_full,
    output logic                        q_push,
    output nir_pkg::match_t             q_wdata
);
    import nir_pkg::*;

    // Strict window test: nom - tol < iv < nom + tol, done without signs.
    function automatic logic near(input logic [TICK_W-1:0] iv,
                                  input logic [TICK_W-1:0] nom,
                                  input logic [TOL_W-1:0]  tol);
        logic [TICK_W:0] iv_plus;
        logic [TICK_W:0] nom_plus;
        begin
            iv_plus  = {1'b0, iv} + {2'b00, tol};
            nom_plus = {1'b0, nom} + {2'b00, tol};
            near = (iv_plus > {1'b0, nom}) && ({1'b0, iv} < nom_plus);
        end
    endfunction

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_wdata.leader = near(s_interval, cfg.leader, cfg.tol);
        q_wdata.rpt    = near(s_interval, cfg.rpt, cfg.tol);
        q_wdata.zero   = near(s_interval, cfg.zero, cfg.tol);
        q_wdata.one    = near(s_interval, cfg.one, cfg.tol);
    end

endmodule

>>> sv/nir_queue.sv
// Short queue of classified words between the front and back ends.
`include "nec_ir_frame_decoder_assert.svh"
module nir_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nir_pkg::match_t wdata,
    output logic            full,
    output logic            not_empty,
    input  logic            pop,
    output nir_pkg::match_t rdata
);
    import nir_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    match_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    `NIR_ASSERT_IMP(a_cnt_bound, 1'b1, count_reg <= FULL_CNT, "queue count over depth")
    `NIR_ASSERT_IMP(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg,
                    "empty queue with unequal pointers")

endmodule

>>> sv/nir_back.sv
// Back end: frame state machine, bit shifter, check-byte test and result register.
`include "nec_ir_frame_decoder_assert.svh"
module nir_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  nir_pkg::match_t               q_rdata,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_res,
    output logic [7:0]                    m_address,
    output logic [7:0]                    m_command
);
    import nir_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [BITCNT_W-1:0]      bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]    frame_reg, frame_next;
    logic [7:0]               last_addr_reg, last_addr_next;
    logic [7:0]               last_cmd_reg, last_cmd_next;
    event_t                   ev_next;
    logic                     m_valid_reg;
    logic [1:0]               m_event_reg;
    logic [7:0]               m_address_reg;
    logic [7:0]               m_command_reg;

    logic                     got_bit;
    logic                     last_bit;
    logic                     check_ok;
    logic [FRAME_BITS-1:0]    frame_shifted;

    // A new word is taken whenever the result register is free or being emptied.
    assign q_pop    = q_not_empty && (!m_valid_reg || m_ready);
    assign got_bit  = q_rdata.zero || q_rdata.one;
    assign last_bit = (bit_count_reg == BITCNT_W'(FRAME_BITS - 1));

    always_comb begin
        frame_shifted = frame_reg;
        frame_shifted[bit_count_reg] = !q_rdata.zero;
        check_ok = (frame_shifted[7:0] == ~frame_shifted[15:8]) &&
                   (frame_shifted[23:16] == ~frame_shifted[31:24]);
    end

    always_comb begin
        phase_next = phase_reg;
        if (q_pop) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    if (q_rdata.leader) begin
                        phase_next = PH_RECV;
                    end else if (q_rdata.rpt) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RECV: begin
                    if (!got_bit) begin
                        phase_next = PH_WAIT;
                    end else if (last_bit) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    always_comb begin
        bit_count_next = bit_count_reg;
        frame_next     = frame_reg;
        last_addr_next = last_addr_reg;
        last_cmd_next  = last_cmd_reg;
        ev_next        = EV_NONE;
        unique case (phase_reg)
            PH_WAIT: begin
                if (q_rdata.leader) begin
                    bit_count_next = '0;
                end else if (q_rdata.rpt) begin
                    ev_next = EV_REPEAT;
                end
            end
            PH_RECV: begin
                if (!got_bit) begin
                    bit_count_next = '0;
                end else begin
                    frame_next = frame_shifted;
                    if (last_bit) begin
                        bit_count_next = '0;
                        if (check_ok) begin
                            last_addr_next = frame_shifted[7:0];
                            last_cmd_next  = frame_shifted[23:16];
                            ev_next        = EV_FRAME;
                        end
                    end else begin
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                end
            end
            default: ev_next = EV_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            frame_reg     <= '0;
            last_addr_reg <= '0;
            last_cmd_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                frame_reg     <= frame_next;
                last_addr_reg <= last_addr_next;
                last_cmd_reg  <= last_cmd_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_event_reg   <= ev_next;
            m_address_reg <= last_addr_next;
            m_command_reg <= last_cmd_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_event_res = m_event_reg;
    assign m_address   = m_address_reg;
    assign m_command   = m_command_reg;

    `NIR_ASSERT_IMP(a_cnt_recv, phase_reg != PH_RECV, bit_count_reg == '0,
                    "bit count nonzero outside reception")
    `NIR_ASSERT_NXT(a_bad_bit, q_pop && phase_reg == PH_RECV && !got_bit,
                    phase_reg == PH_WAIT && bit_count_reg == '0,
                    "unmatched bit interval did not return to leader wait")

endmodule

>>> sv/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder with its configuration registers.
//
//  Channel  Direction  Handshake          Word
//  s_       in         s_valid/s_ready    s_interval (ticks since previous edge)
//  m_       out        m_valid/m_ready    m_event_res, m_address, m_command
//  cfg      in         psel/penable       leader, repeat, zero, one, tolerance
//
// One word is taken per cycle unless the queue is full; each gives exactly one
// result via a queue slot, then the result register of the frame state machine.
// The queue holds QUEUE_DEPTH classified words, so input keeps flowing while
// the result side stalls, until the queue is full.
// Reset is synchronous and active low; it restores the default timing windows.
module nec_ir_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nir_pkg::PADDR_W-1:0]   paddr,
    input  logic [nir_pkg::PDATA_W-1:0]   pwdata,
    output logic [nir_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nir_pkg::TICK_W-1:0]    s_interval,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_res,
    output logic [7:0]                    m_address,
    output logic [7:0]                    m_command
);
    import nir_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;
    logic        q_full;
    logic        q_push;
    match_t      q_wdata;
    logic        q_not_empty;
    logic        q_pop;
    match_t      q_rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader <= LEADER_RST;
            cfg_reg.rpt    <= REPEAT_RST;
            cfg_reg.zero   <= ZERO_RST;
            cfg_reg.one    <= ONE_RST;
            cfg_reg.tol    <= TOL_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LEADER: cfg_reg.leader <= pwdata[TICK_W-1:0];
                REG_REPEAT: cfg_reg.rpt    <= pwdata[TICK_W-1:0];
                REG_ZERO:   cfg_reg.zero   <= pwdata[TICK_W-1:0];
                REG_ONE:    cfg_reg.one    <= pwdata[TICK_W-1:0];
                REG_TOL:    cfg_reg.tol    <= pwdata[TOL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LEADER: prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_reg.leader};
            REG_REPEAT: prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_reg.rpt};
            REG_ZERO:   prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_reg.zero};
            REG_ONE:    prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_reg.one};
            REG_TOL:    prdata = {{(PDATA_W-TOL_W){1'b0}}, cfg_reg.tol};
            default:    prdata = '0;
        endcase
    end

    nir_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_interval (s_interval),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    nir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .rdata     (q_rdata)
    );

    nir_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_address   (m_address),
        .m_command   (m_command)
    );

endmodule
